// ===== hdl/oal_pkg.sv =====
// Shared types and constants of the ordered array list.
`default_nettype none
package oal_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned AT_W   = 5;
  localparam int unsigned LEN_W  = 6;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT       = 3'd0,
    CMD_REMOVE_VALUE = 3'd1,
    CMD_REMOVE_AT    = 3'd2,
    CMD_GET          = 3'd3,
    CMD_SEARCH       = 3'd4
  } cmd_e;

  // Read address choice for the entry memory.
  typedef enum logic [1:0] {
    RD_PTR    = 2'd0,
    RD_PTR_M1 = 2'd1,
    RD_PTR_P1 = 2'd2,
    RD_POS    = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    take;
    logic    ptr_ld_count;
    logic    ptr_ld_pos;
    logic    ptr_ld_zero;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_word;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_fail;
    logic    res_found;
    logic    res_read;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic full;
    logic ptr_gt_pos;
    logic ptr_eq_cnt;
    logic more_after;
    logic match;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/oal_datapath.sv =====
// Entry memory, pointer, count, result and output registers of the list.
`default_nettype none
module oal_datapath #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire oal_pkg::ctrl_t                      ctrl_i,
  output oal_pkg::stat_t                           stat_o,
  input  wire logic [oal_pkg::POS_W-1:0]           pos_i,
  input  wire logic signed [oal_pkg::WORD_W-1:0]   word_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_status_o,
  output logic signed [oal_pkg::WORD_W-1:0]        out_read_word_o,
  output logic                                     out_found_o,
  output logic [oal_pkg::AT_W-1:0]                 out_found_at_o,
  output logic [oal_pkg::LEN_W-1:0]                out_length_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W) + 1;

  logic signed [oal_pkg::WORD_W-1:0] mem [CAPACITY];

  logic [oal_pkg::POS_W-1:0]         pos_q;
  logic signed [oal_pkg::WORD_W-1:0] word_q;
  logic [CW-1:0]                     ptr_q, ptr_d;
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic signed [oal_pkg::WORD_W-1:0] rdata_q;

  logic                              fail_q;
  logic signed [oal_pkg::WORD_W-1:0] rd_word_q;
  logic                              found_q;
  logic [oal_pkg::AT_W-1:0]          at_q;

  logic [CMPW-1:0] pos_x, ptr_x, cnt_x;
  logic [CW-1:0]   ptr_m1, ptr_p1;
  logic [AW-1:0]   raddr;

  assign pos_x  = {{(CMPW-oal_pkg::POS_W){1'b0}}, pos_q};
  assign ptr_x  = {{(CMPW-CW){1'b0}}, ptr_q};
  assign cnt_x  = {{(CMPW-CW){1'b0}}, cnt_q};
  assign ptr_m1 = ptr_q - CW'(1);
  assign ptr_p1 = ptr_q + CW'(1);

  always_comb begin
    case (ctrl_i.rd_sel)
      oal_pkg::RD_PTR:    raddr = ptr_q[AW-1:0];
      oal_pkg::RD_PTR_M1: raddr = ptr_m1[AW-1:0];
      oal_pkg::RD_PTR_P1: raddr = ptr_p1[AW-1:0];
      oal_pkg::RD_POS:    raddr = pos_x[AW-1:0];
      default:            raddr = ptr_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ptr_q[AW-1:0]] <= ctrl_i.wr_word ? word_q : rdata_q;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.ptr_ld_count) begin
      ptr_d = cnt_q;
    end else if (ctrl_i.ptr_ld_pos) begin
      ptr_d = pos_x[CW-1:0];
    end else if (ctrl_i.ptr_ld_zero) begin
      ptr_d = '0;
    end else if (ctrl_i.ptr_inc) begin
      ptr_d = ptr_p1;
    end else if (ctrl_i.ptr_dec) begin
      ptr_d = ptr_m1;
    end
    cnt_d = cnt_q;
    if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Working result of the item in progress.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      pos_q     <= pos_i;
      word_q    <= word_i;
      fail_q    <= 1'b0;
      rd_word_q <= '0;
      found_q   <= 1'b0;
      at_q      <= '0;
    end else begin
      if (ctrl_i.res_fail) begin
        fail_q <= 1'b1;
      end
      if (ctrl_i.res_found) begin
        found_q <= 1'b1;
        at_q    <= ptr_x[oal_pkg::AT_W-1:0];
      end
      if (ctrl_i.res_read) begin
        rd_word_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_status_o    <= fail_q;
      out_read_word_o <= rd_word_q;
      out_found_o     <= found_q;
      out_found_at_o  <= at_q;
      out_length_o    <= cnt_x[oal_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    stat_o.pos_gt_cnt = pos_x > cnt_x;
    stat_o.pos_ge_cnt = pos_x >= cnt_x;
    stat_o.full       = cnt_q == CW'(CAPACITY);
    stat_o.ptr_gt_pos = ptr_x > pos_x;
    stat_o.ptr_eq_cnt = ptr_q == cnt_q;
    stat_o.more_after = (ptr_x + CMPW'(1)) < cnt_x;
    stat_o.match      = rdata_q == word_q;
    stat_o.out_busy   = out_valid_o && !out_ready_i;
  end

endmodule
`default_nettype wire

// ===== hdl/oal_controller.sv =====
// Sequencer that steps the datapath through each list command.
`default_nettype none
module oal_controller (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [oal_pkg::CMD_W-1:0] cmd_i,
  input  wire oal_pkg::stat_t            stat_i,
  output oal_pkg::ctrl_t                 ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INS_RD,
    ST_INS_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_GET_WAIT,
    ST_FINISH
  } state_e;

  state_e        state_q, state_d;
  oal_pkg::cmd_e cmd_q;

  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.take = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (cmd_q)
          oal_pkg::CMD_INSERT: begin
            if (stat_i.pos_gt_cnt || stat_i.full) begin
              ctrl_o.res_fail = 1'b1;
              state_d         = ST_FINISH;
            end else begin
              ctrl_o.ptr_ld_count = 1'b1;
              state_d             = ST_INS_RD;
            end
          end
          oal_pkg::CMD_REMOVE_VALUE, oal_pkg::CMD_SEARCH: begin
            ctrl_o.ptr_ld_zero = 1'b1;
            state_d            = ST_SCAN_RD;
          end
          oal_pkg::CMD_REMOVE_AT: begin
            if (stat_i.pos_ge_cnt) begin
              ctrl_o.res_fail = 1'b1;
              state_d         = ST_FINISH;
            end else begin
              ctrl_o.ptr_ld_pos = 1'b1;
              state_d           = ST_DEL_RD;
            end
          end
          oal_pkg::CMD_GET: begin
            if (stat_i.pos_ge_cnt) begin
              ctrl_o.res_fail = 1'b1;
              state_d         = ST_FINISH;
            end else begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = oal_pkg::RD_POS;
              state_d       = ST_GET_WAIT;
            end
          end
          default: begin
            ctrl_o.res_fail = 1'b1;
            state_d         = ST_FINISH;
          end
        endcase
      end
      // Move entries up from the top until the pointer reaches the slot.
      ST_INS_RD: begin
        if (stat_i.ptr_gt_pos) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = oal_pkg::RD_PTR_M1;
          state_d       = ST_INS_WR;
        end else begin
          ctrl_o.wr_en   = 1'b1;
          ctrl_o.wr_word = 1'b1;
          ctrl_o.cnt_inc = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_INS_WR: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.ptr_dec = 1'b1;
        state_d        = ST_INS_RD;
      end
      ST_SCAN_RD: begin
        if (stat_i.ptr_eq_cnt) begin
          ctrl_o.res_fail = cmd_q == oal_pkg::CMD_REMOVE_VALUE;
          state_d         = ST_FINISH;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = oal_pkg::RD_PTR;
          state_d       = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (stat_i.match) begin
          ctrl_o.res_found = 1'b1;
          state_d = (cmd_q == oal_pkg::CMD_REMOVE_VALUE) ? ST_DEL_RD : ST_FINISH;
        end else begin
          ctrl_o.ptr_inc = 1'b1;
          state_d        = ST_SCAN_RD;
        end
      end
      // Close the gap by pulling each later entry down by one.
      ST_DEL_RD: begin
        if (stat_i.more_after) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = oal_pkg::RD_PTR_P1;
          state_d       = ST_DEL_WR;
        end else begin
          ctrl_o.cnt_dec = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_DEL_WR: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.ptr_inc = 1'b1;
        state_d        = ST_DEL_RD;
      end
      ST_GET_WAIT: begin
        ctrl_o.res_read = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= oal_pkg::CMD_INSERT;
    end else begin
      state_q <= state_d;
      if (ctrl_o.take) begin
        cmd_q <= oal_pkg::cmd_e'(cmd_i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ordered_array_list.sv =====
// Ordered list of signed words kept in a memory with one read and one write port.
//
// The input channel carries one command per item: the command code in tuser, the
// position and the word in tdata. Each item gives exactly one result on the output
// channel: the status in tuser; the read word, found flag, found index and new
// length in tdata.
// Items are handled one at a time. The controller walks the entry memory, which
// reads one address and writes one address per cycle; each moved entry takes a read
// state and a write state, each compared entry a read state and a compare state.
// Insert moves every entry from the position on up by one; search and remove value
// compare entries from index zero until a hit or the end; remove at index and a
// remove value hit pull each later entry down by one. A failed check or unknown
// command goes straight to the result. The result enters the output register as
// the controller returns to idle, and a new item is taken while it waits. If the
// receiver stalls and a second result is ready, the controller holds it until the
// first is taken.
// Reset empties the list at once; the memory itself is not cleared.
`default_nettype none
module ordered_array_list #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // position [4:0], word [36:5], zero fill [39:37]
  input  wire logic [oal_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command [2:0]
  input  wire logic [oal_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // read_word [31:0], found [32], found_at [37:33], length [43:38], zero fill [47:44]
  output logic [oal_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // status [0]
  output logic [0:0]                            m_axis_tuser
);

  oal_pkg::ctrl_t ctrl;
  oal_pkg::stat_t stat;

  logic signed [oal_pkg::WORD_W-1:0] read_word;
  logic                              found;
  logic [oal_pkg::AT_W-1:0]          found_at;
  logic [oal_pkg::LEN_W-1:0]         length;
  logic                              status;

  oal_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  oal_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .pos_i           (s_axis_tdata[4:0]),
    .word_i          (s_axis_tdata[36:5]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_status_o    (status),
    .out_read_word_o (read_word),
    .out_found_o     (found),
    .out_found_at_o  (found_at),
    .out_length_o    (length)
  );

  assign m_axis_tdata = {4'b0000, length, found_at, found, read_word};
  assign m_axis_tuser = status;

endmodule
`default_nettype wire
